// ===== rtl/pfst_pkg.sv =====
`timescale 1ns / 1ps
package pfst_pkg;

    localparam int DIR_PAGES  = 4096;
    localparam int STAGE_SLOTS = 32;
    localparam int DIR_AW     = $clog2(DIR_PAGES);
    localparam int SLOT_AW    = $clog2(STAGE_SLOTS);
    localparam int PAGE_W     = 13;
    localparam int AGE_W      = 16;
    localparam int CNT_W      = $clog2(STAGE_SLOTS + 1);

    typedef enum logic [1:0] {
        CMD_FETCH    = 2'd0,
        CMD_COMPLETE = 2'd1,
        CMD_RELEASE  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_FAILED   = 3'd0,
        ST_READY    = 3'd1,
        ST_PENDING  = 3'd2,
        ST_DEFERRED = 3'd3,
        ST_DONE     = 3'd4
    } t_status;

    localparam logic [1:0] CFG_MAX_READS  = 2'd0;
    localparam logic [1:0] CFG_MAX_STAGED = 2'd1;
    localparam logic [1:0] CFG_PAGES      = 2'd2;

    typedef struct packed {
        logic [DIR_AW-1:0] page;
        logic [AGE_W-1:0]  age;
    } t_slot_ent;

    typedef struct packed {
        logic               match_found;
        logic [SLOT_AW-1:0] match_idx;
        logic               free_found;
        logic [SLOT_AW-1:0] free_idx;
        logic               best_found;
        logic [SLOT_AW-1:0] best_idx;
        logic [DIR_AW-1:0]  best_page;
    } t_scan_res;

endpackage

// ===== rtl/pfst_ram.sv =====
`timescale 1ns / 1ps
module pfst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/pfst_slot_scan.sv =====
`timescale 1ns / 1ps
module pfst_slot_scan import pfst_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [PAGE_W-1:0]      i_key,
    input  logic [STAGE_SLOTS-1:0] i_valid_v,
    input  logic [STAGE_SLOTS-1:0] i_leased_v,
    input  logic [AGE_W-1:0]       i_next_age,
    input  t_slot_ent              i_rd_data,
    output logic [SLOT_AW-1:0]     o_rd_addr,
    output logic                   o_done,
    output t_scan_res              o_res
);
    localparam logic [SLOT_AW-1:0] LAST = SLOT_AW'(STAGE_SLOTS - 1);

    logic               r_busy, r_pend, r_done;
    logic [SLOT_AW-1:0] r_idx, r_pidx;
    logic [AGE_W-1:0]   r_bestd;
    t_scan_res          r_res;
    logic               hit, cand;
    logic [AGE_W-1:0]   age_gap;

    // One slot is compared per cycle, in the cycle after its entry is read.
    always_comb begin
        hit     = i_valid_v[r_pidx] && !i_key[PAGE_W-1] &&
                  (i_rd_data.page == i_key[DIR_AW-1:0]);
        cand    = i_valid_v[r_pidx] && !i_leased_v[r_pidx];
        age_gap = i_next_age - i_rd_data.age;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
            r_pidx <= '0;
            r_res  <= '0;
        end else begin
            r_done <= r_pend && (r_pidx == LAST);
            r_pend <= r_busy;
            r_pidx <= r_idx;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_res.match_found <= 1'b0;
                r_res.free_found  <= 1'b0;
                r_res.best_found  <= 1'b0;
            end else if (r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == LAST) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_pend) begin
                if (hit && !r_res.match_found) begin
                    r_res.match_found <= 1'b1;
                    r_res.match_idx   <= r_pidx;
                end
                if (!i_valid_v[r_pidx] && !r_res.free_found) begin
                    r_res.free_found <= 1'b1;
                    r_res.free_idx   <= r_pidx;
                end
                if (cand && (!r_res.best_found || age_gap > r_bestd)) begin
                    r_res.best_found <= 1'b1;
                    r_res.best_idx   <= r_pidx;
                    r_res.best_page  <= i_rd_data.page;
                    r_bestd          <= age_gap;
                end
            end
        end
    end

    assign o_rd_addr = r_idx;
    assign o_done    = r_done;
    assign o_res     = r_res;
endmodule

// ===== rtl/page_fetch_staging_tracker_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_ready    i_cmd, i_mesh_invalid, i_mesh_base, i_page_offset,
//                                           i_read_ok, i_keep_staged
// result    out        o_valid / i_ready    o_status, o_issue_read, o_slot, o_evicted, o_page,
//                                           o_last
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// After reset the request/failed map is cleared one entry per cycle, o_ready low.
// A slot pass runs through one shared compare unit reading the slot RAM one entry a cycle.
// A failed fetch or a plain done runs from accept through LOOK and DISP to FINAL; a release
// that frees its slot adds a slot pass, a completion a trim check and, if staged, a pass, and
// a fetch that reaches the lookup a trim check, S_FLOOK and a pass. Every eviction adds a trim
// check, a slot pass and the beat itself. Each beat waits until the output register is free;
// the final beat sits in the output register while the next item may already be accepted.
module page_fetch_staging_tracker_unit import pfst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic        i_mesh_invalid,
    input  logic [11:0] i_mesh_base,
    input  logic [11:0] i_page_offset,
    input  logic        i_read_ok,
    input  logic        i_keep_staged,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic        o_issue_read,
    output logic [4:0]  o_slot,
    output logic        o_evicted,
    output logic [12:0] o_page,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data
);
    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LOOK, S_DISP, S_TRIM, S_FLOOK, S_SCAN, S_EVICT, S_FINAL
    } t_state;

    typedef enum logic [1:0] {
        JOB_TRIM, JOB_FETCH, JOB_STAGE, JOB_REL
    } t_job;

    t_state               r_state;
    t_job                 r_job;
    logic                 r_after_fetch;
    logic [DIR_AW-1:0]    r_clr;

    logic [6:0]           r_max_reads;
    logic [5:0]           r_max_staged;
    logic [12:0]          r_pages_stored;

    logic [1:0]           r_cmd;
    logic                 r_inv, r_ok, r_keep;
    logic [PAGE_W-1:0]    r_page;

    logic [STAGE_SLOTS-1:0] r_valid, r_leased;
    logic [CNT_W-1:0]     r_cnt;
    logic [AGE_W-1:0]     r_next_age;
    logic [6:0]           r_inflight;

    t_status              r_fstatus;
    logic                 r_fissue;
    logic [SLOT_AW-1:0]   r_fslot;

    logic                 r_ov, r_oissue, r_oev, r_olast;
    t_status              r_ostatus;
    logic [SLOT_AW-1:0]   r_oslot;
    logic [PAGE_W-1:0]    r_opage;

    // Map RAM word: bit 1 is the requested mark, bit 0 the failed mark.
    logic                 map_we;
    logic [DIR_AW-1:0]    map_waddr;
    logic [1:0]           map_wdata, map_rd;
    logic                 slot_we;
    logic [SLOT_AW-1:0]   slot_waddr, scan_addr;
    t_slot_ent            slot_wdata, slot_rd;
    logic                 scan_start, scan_done;
    t_scan_res            res;

    logic [CNT_W-1:0]     cap;
    logic [6:0]           limit;
    logic                 out_free, out_load;
    logic                 fetch_bad, cmpl_go, rel_go, fetch_issue, stage_hit;
    logic [SLOT_AW-1:0]   stage_idx;

    always_comb begin
        cap         = (r_max_staged == '0) ? CNT_W'(1) : CNT_W'(r_max_staged);
        limit       = (r_max_reads == '0) ? 7'd1 : r_max_reads;
        out_free    = !r_ov || i_ready;
        out_load    = out_free && ((r_state == S_EVICT) || (r_state == S_FINAL));
        fetch_bad   = r_inv || (r_page >= r_pages_stored) || r_page[PAGE_W-1];
        cmpl_go     = (r_cmd == CMD_COMPLETE) && !r_inv && !r_page[PAGE_W-1];
        rel_go      = (r_cmd == CMD_RELEASE) && !r_inv;
        fetch_issue = !map_rd[0] && !res.match_found && !map_rd[1] && (r_inflight < limit);
        stage_hit   = res.match_found || res.free_found;
        stage_idx   = res.match_found ? res.match_idx : res.free_idx;

        map_we    = 1'b0;
        map_waddr = r_page[DIR_AW-1:0];
        map_wdata = 2'b00;
        if (r_state == S_CLR) begin
            map_we    = 1'b1;
            map_waddr = r_clr;
        end else if (r_state == S_DISP && cmpl_go) begin
            // A completion clears the request and marks a failed read.
            map_we    = 1'b1;
            map_wdata = {1'b0, map_rd[0] | !r_ok};
        end else if (r_state == S_SCAN && r_job == JOB_FETCH && scan_done && fetch_issue) begin
            map_we    = 1'b1;
            map_wdata = 2'b10;
        end

        slot_we    = (r_state == S_SCAN) && (r_job == JOB_STAGE) && scan_done && stage_hit;
        slot_waddr = stage_idx;
        slot_wdata = '{page: r_page[DIR_AW-1:0], age: r_next_age};

        scan_start = ((r_state == S_TRIM) && (r_cnt > cap)) || (r_state == S_FLOOK) ||
                     ((r_state == S_DISP) && ((cmpl_go && r_ok) || rel_go));
    end

    pfst_ram #(.WIDTH(2), .DEPTH(DIR_PAGES)) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (r_page[DIR_AW-1:0]),
        .o_rdata (map_rd)
    );

    pfst_ram #(.WIDTH($bits(t_slot_ent)), .DEPTH(STAGE_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (scan_addr),
        .o_rdata (slot_rd)
    );

    pfst_slot_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_key      (r_page),
        .i_valid_v  (r_valid),
        .i_leased_v (r_leased),
        .i_next_age (r_next_age),
        .i_rd_data  (slot_rd),
        .o_rd_addr  (scan_addr),
        .o_done     (scan_done),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLR;
            r_job          <= JOB_TRIM;
            r_after_fetch  <= 1'b0;
            r_clr          <= '0;
            r_max_reads    <= 7'd8;
            r_max_staged   <= 6'd16;
            r_pages_stored <= '0;
            r_valid        <= '0;
            r_leased       <= '0;
            r_cnt          <= '0;
            r_next_age     <= AGE_W'(1);
            r_inflight     <= '0;
            r_ov           <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_READS:  r_max_reads    <= i_cfg_data[6:0];
                    CFG_MAX_STAGED: r_max_staged   <= i_cfg_data[5:0];
                    CFG_PAGES:      r_pages_stored <= i_cfg_data;
                    default: ;
                endcase
            end

            // A new beat may be loaded in the same cycle the old one leaves.
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == DIR_AW'(DIR_PAGES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_inv   <= i_mesh_invalid;
                        r_page  <= {1'b0, i_mesh_base} + {1'b0, i_page_offset};
                        r_ok    <= i_read_ok;
                        r_keep  <= i_keep_staged;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    // The map entry of the new page is read during this cycle.
                    r_state <= S_DISP;
                end
                S_DISP: begin
                    r_fstatus     <= (r_cmd == CMD_FETCH && fetch_bad) ? ST_FAILED : ST_DONE;
                    r_fissue      <= 1'b0;
                    r_fslot       <= '0;
                    r_after_fetch <= (r_cmd == CMD_FETCH) && !fetch_bad;
                    if (r_cmd == CMD_FETCH) begin
                        r_state <= fetch_bad ? S_FINAL : S_TRIM;
                    end else if (cmpl_go) begin
                        if (map_rd[1] && r_inflight != '0) begin
                            r_inflight <= r_inflight - 1'b1;
                        end
                        if (r_ok) begin
                            r_job   <= JOB_STAGE;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_TRIM;
                        end
                    end else if (rel_go) begin
                        r_job   <= JOB_REL;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_FINAL;
                    end
                end
                S_TRIM: begin
                    if (r_cnt > cap) begin
                        r_job   <= JOB_TRIM;
                        r_state <= S_SCAN;
                    end else if (r_after_fetch) begin
                        r_state <= S_FLOOK;
                    end else begin
                        r_state <= S_FINAL;
                    end
                end
                S_FLOOK: begin
                    r_job   <= JOB_FETCH;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_done) begin
                        unique case (r_job)
                            JOB_TRIM: begin
                                if (res.best_found) begin
                                    r_state <= S_EVICT;
                                end else if (r_after_fetch) begin
                                    r_state <= S_FLOOK;
                                end else begin
                                    r_state <= S_FINAL;
                                end
                            end
                            JOB_FETCH: begin
                                r_state <= S_FINAL;
                                if (map_rd[0]) begin
                                    r_fstatus <= ST_FAILED;
                                end else if (res.match_found) begin
                                    r_leased[res.match_idx] <= 1'b1;
                                    r_fstatus <= ST_READY;
                                    r_fslot   <= res.match_idx;
                                end else if (map_rd[1]) begin
                                    r_fstatus <= ST_PENDING;
                                end else if (r_inflight >= limit) begin
                                    r_fstatus <= ST_DEFERRED;
                                end else begin
                                    r_fstatus  <= ST_PENDING;
                                    r_fissue   <= 1'b1;
                                    r_inflight <= r_inflight + 1'b1;
                                end
                            end
                            JOB_STAGE: begin
                                // With every slot taken and no older copy the page is dropped.
                                if (stage_hit) begin
                                    r_valid[stage_idx]  <= 1'b1;
                                    r_leased[stage_idx] <= 1'b0;
                                    r_next_age          <= r_next_age + 1'b1;
                                    if (!res.match_found) begin
                                        r_cnt <= r_cnt + 1'b1;
                                    end
                                end
                                r_state <= S_TRIM;
                            end
                            JOB_REL: begin
                                if (res.match_found) begin
                                    r_leased[res.match_idx] <= 1'b0;
                                    if (!r_keep) begin
                                        r_valid[res.match_idx] <= 1'b0;
                                        r_cnt <= r_cnt - 1'b1;
                                    end
                                end
                                r_state <= (res.match_found && r_keep) ? S_TRIM : S_FINAL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EVICT: begin
                    if (out_free) begin
                        r_ostatus <= ST_DONE;
                        r_oissue  <= 1'b0;
                        r_oslot   <= res.best_idx;
                        r_oev     <= 1'b1;
                        r_opage   <= {1'b0, res.best_page};
                        r_olast   <= 1'b0;
                        r_valid[res.best_idx]  <= 1'b0;
                        r_leased[res.best_idx] <= 1'b0;
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_TRIM;
                    end
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_ostatus <= r_fstatus;
                        r_oissue  <= r_fissue;
                        r_oslot   <= r_fslot;
                        r_oev     <= 1'b0;
                        r_opage   <= r_page;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_ov;
    assign o_status     = r_ostatus;
    assign o_issue_read = r_oissue;
    assign o_slot       = r_oslot;
    assign o_evicted    = r_oev;
    assign o_page       = r_opage;
    assign o_last       = r_olast;
endmodule

// ===== rtl/pfst_checker.sv =====
`timescale 1ns / 1ps
module pfst_checker import pfst_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic        o_issue_read,
    input logic [4:0]  o_slot,
    input logic        o_evicted,
    input logic [12:0] o_page,
    input logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_page) && $stable(o_last))
        else $error("result beat changed while stalled");

    a_evict_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted |-> !o_last && !o_issue_read && o_status == ST_DONE)
        else $error("eviction beat malformed");

    a_issue_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_issue_read |-> o_last && o_status == ST_PENDING)
        else $error("issued read outside a pending final beat");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last && o_status != ST_READY |-> o_slot == 5'd0)
        else $error("slot reported on a non-ready final beat");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while busy");
endmodule

bind page_fetch_staging_tracker_unit pfst_checker u_pfst_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import pfst_pkg::*;

    // Generous ceiling: every item at its most beats, each beat behind a long stall.
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 200;
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        bit          inv;
        bit [11:0]   base;
        bit [11:0]   off;
        bit          ok;
        bit          keep;
        bit          typed;
        t_status     st;
        bit          iss;
        bit [4:0]    slot;
    } t_req;

    typedef struct {
        t_status     st;
        bit          iss;
        bit [4:0]    slot;
        bit          ev;
        bit [12:0]   page;
        bit          last;
    } t_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = '0;
    logic        i_mesh_invalid = 1'b0;
    logic [11:0] i_mesh_base = '0;
    logic [11:0] i_page_offset = '0;
    logic        i_read_ok = 1'b0;
    logic        i_keep_staged = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic        o_issue_read;
    logic [4:0]  o_slot;
    logic        o_evicted;
    logic [12:0] o_page;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [12:0] i_cfg_data = '0;

    page_fetch_staging_tracker_unit dut (.*);

    // Shadow copy of the tracker state, updated as each input beat is accepted.
    bit        pm_requested [DIR_PAGES];
    bit        pm_failed    [DIR_PAGES];
    bit        sl_valid     [STAGE_SLOTS];
    bit        sl_leased    [STAGE_SLOTS];
    bit [12:0] sl_page      [STAGE_SLOTS];
    bit [15:0] sl_age       [STAGE_SLOTS];
    bit [15:0] age_next = 16'd1;
    bit [6:0]  reads_out = '0;
    bit [6:0]  lim_reads = 7'd8;
    bit [5:0]  lim_staged = 6'd16;
    bit [12:0] dir_size = '0;

    t_beat     pending_beats [$];
    bit [12:0] issued_pages [$];
    t_req      script [$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;
    int        stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The run is bounded no matter what the block does.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Result-side backpressure: random stall bursts except in the quiet tail.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 16) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Every accepted result beat is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected result beat: status %0d page %0d", o_status, o_page);
                errors++;
            end else begin
                want = pending_beats[0];
                pending_beats.delete(0);
                if (o_status !== want.st) begin
                    $error("status: expected %0d, got %0d", want.st, o_status);
                    errors++;
                end
                if (o_issue_read !== want.iss) begin
                    $error("issue_read: expected %0d, got %0d", want.iss, o_issue_read);
                    errors++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    errors++;
                end
                if (o_evicted !== want.ev) begin
                    $error("evicted: expected %0d, got %0d", want.ev, o_evicted);
                    errors++;
                end
                if (o_page !== want.page) begin
                    $error("page: expected %0d, got %0d", want.page, o_page);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    errors++;
                end
            end
        end
    end

    function automatic void push_beat(t_status st, bit iss, bit [4:0] slot, bit ev,
                                      bit [12:0] page, bit last);
        t_beat b;
        b.st = st;
        b.iss = iss;
        b.slot = slot;
        b.ev = ev;
        b.page = page;
        b.last = last;
        pending_beats = {pending_beats, b};
    endfunction

    function automatic int slot_of(bit [12:0] page);
        for (int i = 0; i < STAGE_SLOTS; i++)
            if (sl_valid[i] && sl_page[i] == page)
                return i;
        return -1;
    endfunction

    // Evict the oldest unleased slots while the staged count is above the cap.
    // Age distance is taken modulo 2^16 so a wrapped counter still orders correctly.
    function automatic void evict_to_cap();
        int        staged;
        int        pick;
        bit [15:0] gap;
        bit [15:0] far;
        int        cap;
        cap = (lim_staged == 0) ? 1 : lim_staged;
        forever begin
            staged = 0;
            for (int i = 0; i < STAGE_SLOTS; i++)
                staged += sl_valid[i];
            if (staged <= cap)
                return;
            pick = -1;
            far = '0;
            for (int i = 0; i < STAGE_SLOTS; i++) begin
                if (sl_valid[i] && !sl_leased[i]) begin
                    gap = age_next - sl_age[i];
                    if (pick < 0 || gap > far) begin
                        pick = i;
                        far = gap;
                    end
                end
            end
            if (pick < 0)
                return;
            sl_valid[pick] = 1'b0;
            sl_leased[pick] = 1'b0;
            push_beat(ST_DONE, 1'b0, pick[4:0], 1'b1, sl_page[pick], 1'b0);
        end
    endfunction

    // A completed page takes its old slot if it has one, else the first free slot,
    // else it is dropped.
    function automatic void stage_page(bit [12:0] page);
        int s;
        s = slot_of(page);
        if (s < 0)
            for (int i = 0; i < STAGE_SLOTS; i++)
                if (s < 0 && !sl_valid[i])
                    s = i;
        if (s < 0)
            return;
        sl_valid[s] = 1'b1;
        sl_leased[s] = 1'b0;
        sl_page[s] = page;
        sl_age[s] = age_next;
        age_next = age_next + 16'd1;
    endfunction

    // Work out every beat one accepted request causes and queue them in order.
    function automatic void predict_tracker(t_req r);
        bit [12:0] page;
        int        lim;
        int        s;
        t_status   st;
        bit        iss;
        bit [4:0]  slot;
        page = {1'b0, r.base} + {1'b0, r.off};
        st = ST_DONE;
        iss = 1'b0;
        slot = '0;
        if (r.cmd == CMD_FETCH) begin
            lim = (lim_reads == 0) ? 1 : lim_reads;
            if (r.inv || page >= dir_size || page >= DIR_PAGES) begin
                st = ST_FAILED;
            end else begin
                evict_to_cap();
                s = slot_of(page);
                if (pm_failed[page]) begin
                    st = ST_FAILED;
                end else if (s >= 0) begin
                    sl_leased[s] = 1'b1;
                    st = ST_READY;
                    slot = s[4:0];
                end else if (pm_requested[page]) begin
                    st = ST_PENDING;
                end else if (reads_out >= lim) begin
                    st = ST_DEFERRED;
                end else begin
                    pm_requested[page] = 1'b1;
                    reads_out = reads_out + 7'd1;
                    st = ST_PENDING;
                    iss = 1'b1;
                    issued_pages = {issued_pages, page};
                end
            end
        end else if (r.cmd == CMD_COMPLETE && !r.inv && page < DIR_PAGES) begin
            // A completion for a page never requested still stages or fails it.
            if (pm_requested[page]) begin
                pm_requested[page] = 1'b0;
                if (reads_out != 0)
                    reads_out = reads_out - 7'd1;
            end
            if (r.ok)
                stage_page(page);
            else
                pm_failed[page] = 1'b1;
            evict_to_cap();
        end else if (r.cmd == CMD_RELEASE && !r.inv) begin
            s = slot_of(page);
            if (s >= 0) begin
                sl_leased[s] = 1'b0;
                if (r.keep)
                    evict_to_cap();
                else
                    sl_valid[s] = 1'b0;
            end
        end
        // Directed rows with a hand-written answer override the final beat.
        if (r.typed) begin
            st = r.st;
            iss = r.iss;
            slot = r.slot;
        end
        push_beat(st, iss, slot, 1'b0, page, 1'b1);
    endfunction

    function automatic t_req mk(int cmd, int inv, int base, int off, int ok, int keep);
        t_req r;
        r.cmd = cmd[1:0];
        r.inv = (inv != 0);
        r.base = base[11:0];
        r.off = off[11:0];
        r.ok = (ok != 0);
        r.keep = (keep != 0);
        r.typed = 1'b0;
        r.st = ST_DONE;
        r.iss = 1'b0;
        r.slot = '0;
        return r;
    endfunction

    function automatic t_req mk_typed(int cmd, int inv, int base, int off,
                                      int ok, int keep, t_status st, int iss, int slot);
        t_req r;
        r = mk(cmd, inv, base, off, ok, keep);
        r.typed = 1'b1;
        r.st = st;
        r.iss = (iss != 0);
        r.slot = slot[4:0];
        return r;
    endfunction

    function automatic void add_row(t_req r);
        script = {script, r};
    endfunction

    // Present one request and hold it until the block takes it. Valid stays high
    // afterwards; the caller lowers it before any gap.
    task automatic send_req(t_req r);
        i_valid <= 1'b1;
        i_cmd <= r.cmd;
        i_mesh_invalid <= r.inv;
        i_mesh_base <= r.base;
        i_page_offset <= r.off;
        i_read_ok <= r.ok;
        i_keep_staged <= r.keep;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_tracker(r);
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Drain all outstanding beats, then allow for any trailing internal work.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Only called while the block is idle. The enable is lowered by the caller
    // so that back-to-back writes never drop and raise it in one step.
    task automatic write_reg(logic [1:0] idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value[12:0];
        @(posedge i_clk);
        case (idx)
            CFG_MAX_READS:  lim_reads = value[6:0];
            CFG_MAX_STAGED: lim_staged = value[5:0];
            CFG_PAGES:      dir_size = value[12:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(int reads, int staged, int pages);
        write_reg(CFG_MAX_READS, reads);
        write_reg(CFG_MAX_STAGED, staged);
        write_reg(CFG_PAGES, pages);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random traffic biased toward well-formed fetch, complete and release
    // sequences on a small page window, with some full-range noise.
    task automatic random_phase(int count, int window);
        t_req      r;
        int        pg;
        int        pick;
        int        kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 99);
            if ($urandom_range(0, 6) == 0) begin
                r = mk($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 1), $urandom_range(0, 1));
            end else begin
                pg = $urandom_range(0, window - 1);
                if (kind < 40) begin
                    r = mk(CMD_FETCH, 0, 0, 0, 0, 0);
                end else if (kind < 70) begin
                    r = mk(CMD_COMPLETE, 0, 0, 0, $urandom_range(0, 4) != 0, 0);
                    if (issued_pages.size() != 0 && $urandom_range(0, 4) != 0) begin
                        pick = $urandom_range(0, issued_pages.size() - 1);
                        pg = issued_pages[pick];
                        issued_pages.delete(pick);
                    end
                end else if (kind < 96) begin
                    r = mk(CMD_RELEASE, 0, 0, 0, 0, $urandom_range(0, 1));
                end else begin
                    r = mk(CMD_UNKNOWN, 0, 0, 0, 0, 0);
                end
                r.base = 12'($urandom_range(0, pg));
                r.off = 12'(pg - int'(r.base));
                r.inv = ($urandom_range(0, 19) == 0);
            end
            send_req(r);
            maybe_gap();
        end
    endtask

    initial begin
        for (int i = 0; i < DIR_PAGES; i++) begin
            pm_requested[i] = 1'b0;
            pm_failed[i] = 1'b0;
        end
        for (int i = 0; i < STAGE_SLOTS; i++) begin
            sl_valid[i] = 1'b0;
            sl_leased[i] = 1'b0;
            sl_page[i] = '0;
            sl_age[i] = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight out of reset the directory is empty: every fetch fails, and
        // invalid meshes, stray completions, unknown commands just answer done.
        add_row(mk_typed(CMD_FETCH, 0, 0, 0, 0, 0, ST_FAILED, 0, 0));
        add_row(mk_typed(CMD_FETCH, 1, 4095, 4095, 1, 1, ST_FAILED, 0, 0));
        add_row(mk_typed(CMD_COMPLETE, 1, 3, 0, 1, 0, ST_DONE, 0, 0));
        add_row(mk_typed(CMD_COMPLETE, 0, 4095, 4095, 1, 0, ST_DONE, 0, 0));
        add_row(mk_typed(CMD_RELEASE, 0, 9, 0, 0, 1, ST_DONE, 0, 0));
        add_row(mk_typed(CMD_RELEASE, 1, 9, 0, 0, 0, ST_DONE, 0, 0));
        add_row(mk_typed(CMD_UNKNOWN, 0, 1, 1, 1, 1, ST_DONE, 0, 0));
        foreach (script[i]) begin
            send_req(script[i]);
            maybe_gap();
        end
        wait_idle();

        // One read in flight at most, one staged page as the cap.
        set_limits(1, 1, 4096);
        script.delete();
        add_row(mk_typed(CMD_FETCH, 0, 2, 3, 0, 0, ST_PENDING, 1, 0));
        add_row(mk_typed(CMD_FETCH, 0, 6, 0, 0, 0, ST_DEFERRED, 0, 0));
        add_row(mk_typed(CMD_FETCH, 0, 0, 5, 0, 0, ST_PENDING, 0, 0));
        add_row(mk_typed(CMD_COMPLETE, 0, 5, 0, 1, 0, ST_DONE, 0, 0));
        add_row(mk_typed(CMD_FETCH, 0, 5, 0, 0, 0, ST_READY, 0, 0));
        add_row(mk(CMD_COMPLETE, 0, 7, 0, 1, 0));
        add_row(mk(CMD_COMPLETE, 0, 6, 0, 0, 0));
        add_row(mk_typed(CMD_FETCH, 0, 6, 0, 0, 0, ST_FAILED, 0, 0));
        add_row(mk(CMD_RELEASE, 0, 5, 0, 0, 1));
        add_row(mk(CMD_COMPLETE, 0, 4095, 0, 1, 0));
        add_row(mk(CMD_FETCH, 0, 0, 4095, 0, 0));
        add_row(mk(CMD_RELEASE, 0, 4095, 0, 0, 0));
        add_row(mk_typed(CMD_FETCH, 0, 4095, 4095, 0, 0, ST_FAILED, 0, 0));
        foreach (script[i]) begin
            send_req(script[i]);
            maybe_gap();
        end
        wait_idle();

        // Random phases across several limit settings, zeros and maxima among them.
        set_limits(64, 32, 4096);
        random_phase(40, 48);
        wait_idle();
        set_limits(0, 0, 30);
        random_phase(30, 40);
        wait_idle();
        set_limits(3, 4, 200);
        random_phase(30, 24);
        wait_idle();
        set_limits(8, 16, 4095);
        random_phase(30, 40);
        wait_idle();
        set_limits(64, 2, 16);
        quiet = 1'b1;
        random_phase(30, 20);
        wait_idle();

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/pfst_pkg.sv
rtl/pfst_ram.sv
rtl/pfst_slot_scan.sv
rtl/page_fetch_staging_tracker_unit.sv
rtl/pfst_checker.sv
sim/tb.sv
